FILE: rtl/flcc_pkg.sv
// Shared types and constants for the free list coalesce and compact block.
// Used by the core and by its port checker; no dependencies.
`default_nettype none
package flcc_pkg;

  localparam logic [31:0] FreeBit   = 32'h8000_0000;
  localparam logic [31:0] TailBit   = 32'h4000_0000;
  localparam logic [31:0] EmptyWord = 32'h2FFF_FFFF;
  localparam logic [31:0] AddrMask  = 32'h0FFF_FFFF;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 72;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_COLLECT = 2'd2,
    OP_SETTAIL = 2'd3
  } op_e;

  // One table entry: size in the upper word, address word in the lower one.
  typedef struct packed {
    logic [31:0] size;
    logic [31:0] addr;
  } rec_t;

endpackage
`default_nettype wire

FILE: rtl/free_list_coalesce_compact_core.sv
// Top level of the free list coalesce and compact block.
// Depends on flcc_pkg; holds the record table as a single-port-write memory.
`default_nettype none
// Holds RECORDS allocation records and executes write, read, set-tail and
// collect requests one at a time. After reset the table is cleared by a pass
// that writes one entry a cycle through all RECORDS entries before the first
// request is taken. Write and set-tail requests go from idle to the done
// state; reads pass through a read-wait state first. Collect runs merge,
// zero-size, sort, tail move and fold passes; the merge and sort passes
// dominate, as nested scans through the single table read port. A finished
// result, tail index included, waits in an output register, and a new request
// is accepted as soon as the sequencer is idle.
module free_list_coalesce_compact_core #(
  parameter int unsigned RECORDS = 32
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // Fields from bit 0: operation[1:0], index[6:2], addr_word[38:7], size_word[70:39].
  input  wire  [flcc_pkg::InDataW-1:0]          s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  wire                                   m_axis_tready_i,
  // Fields from bit 0: entry_addr[31:0], entry_size[63:32], tail_index[68:64].
  output logic [flcc_pkg::OutDataW-1:0]         m_axis_tdata_o
);
  import flcc_pkg::*;

  localparam int unsigned IW = $clog2(RECORDS);
  localparam int unsigned CW = $clog2(RECORDS + 1);

  typedef enum logic [23:0] {
    ST_CLR  = 24'h000001, ST_IDLE = 24'h000002, ST_RDW  = 24'h000004,
    ST_DONE = 24'h000008, ST_M_RI = 24'h000010, ST_M_CI = 24'h000020,
    ST_M_RJ = 24'h000040, ST_M_CJ = 24'h000080, ST_M_WI = 24'h000100,
    ST_Z_R  = 24'h000200, ST_Z_C  = 24'h000400, ST_S_RI = 24'h000800,
    ST_S_CI = 24'h001000, ST_S_RJ = 24'h002000, ST_S_CJ = 24'h004000,
    ST_S_SW = 24'h008000, ST_T_R  = 24'h010000, ST_T_C  = 24'h020000,
    ST_T_RT = 24'h040000, ST_T_CT = 24'h080000, ST_F_RT = 24'h100000,
    ST_F_CT = 24'h200000, ST_F_RK = 24'h400000, ST_F_CK = 24'h800000
  } state_e;

  rec_t mem [RECORDS];
  rec_t rd_q;
  logic [IW-1:0] rd_idx;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  rec_t          wr_rec;

  state_e      state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  rec_t        a_q, a_d, b_q, b_d;
  logic [4:0]  tail_q, tail_d;
  op_e         op_q, op_d;
  logic        ok_q, ok_d;
  logic        ov_q, ov_d;
  logic [31:0] oaddr_q, oaddr_d, osize_q, osize_d;
  logic [4:0]  otail_q, otail_d;

  op_e         in_op;
  logic [4:0]  in_idx;
  rec_t        in_rec;
  logic        in_ok, acc;
  logic [CW-1:0] ip1, jp1, tail_c, rec_c;
  logic [IW-1:0] tail_m, tailm1_m;
  logic [31:0] merge_end;

  assign in_op  = op_e'(s_axis_tdata_i[1:0]);
  assign in_idx = s_axis_tdata_i[6:2];
  assign in_rec = '{size: s_axis_tdata_i[70:39], addr: s_axis_tdata_i[38:7]};
  assign in_ok  = (32'(in_idx) < RECORDS);
  assign acc    = s_axis_tvalid_i && s_axis_tready_o;

  assign ip1      = i_q + CW'(1);
  assign jp1      = j_q + CW'(1);
  assign tail_c   = CW'(tail_q);
  assign rec_c    = CW'(RECORDS);
  assign tail_m   = IW'(tail_q);
  assign tailm1_m = IW'(tail_q - 5'd1);
  assign merge_end = (a_q.addr & AddrMask) + a_q.size;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {3'b000, otail_q, osize_q, oaddr_q};

  always_comb begin
    state_d = state_q;
    i_d = i_q; j_d = j_q; a_d = a_q; b_d = b_q;
    tail_d = tail_q; op_d = op_q; ok_d = ok_q;
    ov_d = ov_q; oaddr_d = oaddr_q; osize_d = osize_q; otail_d = otail_q;
    rd_idx = i_q[IW-1:0];
    wr_en = 1'b0; wr_idx = i_q[IW-1:0]; wr_rec = a_q;
    if (ov_q && m_axis_tready_i) begin
      ov_d = 1'b0;
    end
    case (state_q)
      ST_CLR: begin
        wr_en = 1'b1;
        wr_rec = '{size: 32'd0, addr: EmptyWord};
        if (ip1 == rec_c) begin
          i_d = '0;
          state_d = ST_IDLE;
        end else begin
          i_d = ip1;
        end
      end
      ST_IDLE: begin
        rd_idx = IW'(in_idx);
        if (acc) begin
          op_d = in_op;
          ok_d = in_ok;
          i_d = '0;
          case (in_op)
            OP_WRITE: begin
              wr_en = in_ok;
              wr_idx = IW'(in_idx);
              wr_rec = in_rec;
              state_d = ST_DONE;
            end
            OP_READ: state_d = ST_RDW;
            OP_COLLECT: state_d = ST_M_RI;
            OP_SETTAIL: begin
              if (in_ok) tail_d = in_idx;
              state_d = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_RDW: begin
        a_d = rd_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_q || m_axis_tready_i) begin
          ov_d = 1'b1;
          otail_d = tail_q;
          if (op_q == OP_READ && ok_q) begin
            oaddr_d = a_q.addr;
            osize_d = a_q.size;
          end else begin
            oaddr_d = '0;
            osize_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      // Merge pass.
      ST_M_RI: state_d = ST_M_CI;
      ST_M_CI: begin
        a_d = rd_q;
        if ((rd_q.addr & FreeBit) != 0 && ip1 < rec_c) begin
          j_d = ip1;
          state_d = ST_M_RJ;
        end else if (ip1 > tail_c) begin
          i_d = '0;
          state_d = ST_Z_R;
        end else begin
          i_d = ip1;
          state_d = ST_M_RI;
        end
      end
      ST_M_RJ: begin
        rd_idx = j_q[IW-1:0];
        state_d = ST_M_CJ;
      end
      ST_M_CJ: begin
        if (rd_q.addr == EmptyWord && jp1 < rec_c) begin
          j_d = jp1;
          state_d = ST_M_RJ;
        end else if (rd_q.addr != EmptyWord && (rd_q.addr & FreeBit) != 0 &&
                     (rd_q.addr & AddrMask) == merge_end) begin
          wr_en = 1'b1;
          wr_idx = j_q[IW-1:0];
          wr_rec = '{size: rd_q.size, addr: EmptyWord};
          a_d.size = a_q.size + rd_q.size;
          state_d = ST_M_WI;
        end else if (ip1 > tail_c) begin
          i_d = '0;
          state_d = ST_Z_R;
        end else begin
          i_d = ip1;
          state_d = ST_M_RI;
        end
      end
      ST_M_WI: begin
        // The grown record is written back and scanned again from its neighbor.
        wr_en = 1'b1;
        j_d = ip1;
        state_d = ST_M_RJ;
      end
      // Zero-size pass.
      ST_Z_R: state_d = ST_Z_C;
      ST_Z_C: begin
        if (rd_q.size == 32'd0) begin
          wr_en = 1'b1;
          wr_rec = '{size: rd_q.size, addr: EmptyWord};
        end
        if (ip1 > tail_c) begin
          i_d = '0;
          state_d = ST_S_RI;
        end else begin
          i_d = ip1;
          state_d = ST_Z_R;
        end
      end
      // Exchange sort up to the first tail-flagged record or the tail index.
      ST_S_RI: state_d = ST_S_CI;
      ST_S_CI: begin
        a_d = rd_q;
        if ((rd_q.addr & TailBit) != 0) begin
          i_d = '0;
          state_d = ST_T_R;
        end else if (ip1 <= tail_c) begin
          j_d = ip1;
          state_d = ST_S_RJ;
        end else begin
          i_d = '0;
          state_d = ST_T_R;
        end
      end
      ST_S_RJ: begin
        rd_idx = j_q[IW-1:0];
        state_d = ST_S_CJ;
      end
      ST_S_CJ: begin
        if ((rd_q.addr & TailBit) != 0 || ((rd_q.addr & AddrMask) >=
            (a_q.addr & AddrMask) && jp1 > tail_c)) begin
          if (ip1 > tail_c) begin
            i_d = '0;
            state_d = ST_T_R;
          end else begin
            i_d = ip1;
            state_d = ST_S_RI;
          end
        end else if ((rd_q.addr & AddrMask) < (a_q.addr & AddrMask)) begin
          wr_en = 1'b1;
          wr_rec = rd_q;
          b_d = rd_q;
          state_d = ST_S_SW;
        end else begin
          j_d = jp1;
          state_d = ST_S_RJ;
        end
      end
      ST_S_SW: begin
        wr_en = 1'b1;
        wr_idx = j_q[IW-1:0];
        wr_rec = a_q;
        a_d = b_q;
        if (jp1 > tail_c) begin
          if (ip1 > tail_c) begin
            i_d = '0;
            state_d = ST_T_R;
          end else begin
            i_d = ip1;
            state_d = ST_S_RI;
          end
        end else begin
          j_d = jp1;
          state_d = ST_S_RJ;
        end
      end
      // Move the tail into the first empty slot.
      ST_T_R: state_d = ST_T_C;
      ST_T_C: begin
        if ((rd_q.addr & TailBit) != 0) begin
          state_d = ST_F_RT;
        end else if (rd_q.addr == EmptyWord) begin
          state_d = ST_T_RT;
        end else if (ip1 > tail_c) begin
          state_d = ST_F_RT;
        end else begin
          i_d = ip1;
          state_d = ST_T_R;
        end
      end
      ST_T_RT: begin
        rd_idx = tail_m;
        state_d = ST_T_CT;
      end
      ST_T_CT: begin
        wr_en = 1'b1;
        wr_rec = rd_q;
        tail_d = 5'(i_q);
        state_d = ST_F_RT;
      end
      // Fold free records in front of the tail.
      ST_F_RT: begin
        rd_idx = tail_m;
        state_d = (tail_q == 5'd0) ? ST_DONE : ST_F_CT;
      end
      ST_F_CT: begin
        b_d = rd_q;
        state_d = ST_F_RK;
      end
      ST_F_RK: begin
        rd_idx = tailm1_m;
        state_d = ST_F_CK;
      end
      ST_F_CK: begin
        if ((rd_q.addr & FreeBit) != 0) begin
          wr_en = 1'b1;
          wr_idx = tailm1_m;
          wr_rec = '{size: rd_q.size + b_q.size, addr: (rd_q.addr & AddrMask) | TailBit};
          b_d = wr_rec;
          tail_d = tail_q - 5'd1;
          state_d = (tail_q == 5'd1) ? ST_DONE : ST_F_RK;
        end else begin
          state_d = ST_DONE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_idx] <= wr_rec;
    rd_q <= mem[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      i_q <= '0;
      tail_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q <= i_d;
      tail_q <= tail_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d;
    a_q <= a_d;
    b_q <= b_d;
    op_q <= op_d;
    ok_q <= ok_d;
    oaddr_q <= oaddr_d;
    osize_q <= osize_d;
    otail_q <= otail_d;
  end

endmodule
`default_nettype wire

FILE: rtl/flcc_checker.sv
// Port-level checker for the free list coalesce and compact core.
// Depends on flcc_pkg; bound to the top level at the end of this file.
`default_nettype none
module flcc_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          s_axis_tvalid_i,
  input wire                          s_axis_tready_o,
  input wire [flcc_pkg::InDataW-1:0]  s_axis_tdata_i,
  input wire                          m_axis_tvalid_o,
  input wire                          m_axis_tready_i,
  input wire [flcc_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import flcc_pkg::*;

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed under stall");

  // An accepted request takes the sequencer out of idle, so ready drops.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready right after a request");

  // A new result is issued as the sequencer returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("result without idle sequencer");

  // A set-tail request with no result pending reports that index once it has passed the done state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i[1:0] == OP_SETTAIL &&
    !m_axis_tvalid_o
    |=> ##1 m_axis_tvalid_o && m_axis_tdata_o[68:64] == $past(s_axis_tdata_i[6:2], 2))
    else $error("set-tail result mismatch");

endmodule

bind free_list_coalesce_compact_core flcc_checker u_flcc_checker (.*);
`default_nettype wire
